// ===== rtl/utf8_latin1_transcode_slice_defines.svh =====
// Assertion macros for the UTF-8 / Latin-1 transcoder.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef UTF8_LATIN1_TRANSCODE_SLICE_DEFINES_SVH
`define UTF8_LATIN1_TRANSCODE_SLICE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define ULT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ULT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/ult_pkg.sv =====
// Package for the UTF-8 / Latin-1 transcoder: payload structs, mode and
// register codes, lead-byte class constants. No dependencies.
`timescale 1ns / 1ps

package ult_pkg;

  typedef enum logic [1:0] {
    MODE_DECODE = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_COUNT  = 2'd2,
    MODE_SLICE  = 2'd3
  } mode_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LAST  = 2'd2;

  // lead-byte class boundaries
  localparam logic [7:0] LEAD_2B = 8'hc0;
  localparam logic [7:0] LEAD_3B = 8'he0;
  localparam logic [7:0] LEAD_4B = 8'hf0;
  localparam logic [7:0] LEAD_5B = 8'hf8;
  localparam logic [7:0] LEAD_6B = 8'hfc;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] CONT_MASK = 8'h3f;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_summary;
    logic [15:0] count;
    logic        status;
    logic        last_of_run;
  } out_item_t;

  // continuation bytes that follow a lead byte
  function automatic logic [2:0] extra_bytes(input logic [7:0] b);
    logic [2:0] n;
    begin
      if (b < LEAD_2B)      n = 3'd0;
      else if (b < LEAD_3B) n = 3'd1;
      else if (b < LEAD_4B) n = 3'd2;
      else if (b < LEAD_5B) n = 3'd3;
      else if (b < LEAD_6B) n = 3'd4;
      else                  n = 3'd5;
      return n;
    end
  endfunction

endpackage

// ===== rtl/utf8_latin1_transcode_slice.sv =====
// Top level of the UTF-8 / Latin-1 transcoder with count and slice modes.
// Path: input register, then result register, which offers the results.
// Throughput: one request per cycle when it yields at most one result and
// no stall; else input waits while the single result register drains (max 3).
// Reset: synchronous, active low; clears modes, counters and both stages.
// Depends on ult_pkg and utf8_latin1_transcode_slice_defines.svh.
`timescale 1ns / 1ps
`include "utf8_latin1_transcode_slice_defines.svh"

module utf8_latin1_transcode_slice
  import ult_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SHOW_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

  // counters saturate at full scale
  function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
    begin
      return (v == CNT_MAX) ? v : v + 1'b1;
    end
  endfunction

  // count field: counter clamped to 16 bits
  function automatic logic [15:0] shown(input logic [LENGTH_BITS-1:0] v);
    logic [SHOW_W-1:0] w;
    begin
      w = SHOW_W'(v);
      return (w > SHOW_W'(16'hffff)) ? 16'hffff : w[15:0];
    end
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  mode_t       mode_r;
  logic [15:0] range_first_r;
  logic [15:0] range_last_r;
  logic        mode_wr;

  assign mode_wr = cfg_we && (cfg_index == REG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_DECODE;
      range_first_r <= '0;
      range_last_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:        mode_r        <= mode_t'(cfg_wdata[1:0]);
        REG_RANGE_FIRST: range_first_r <= cfg_wdata;
        REG_RANGE_LAST:  range_last_r  <= cfg_wdata;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register. A held request moves into the result register once
  // the result register is empty or hands over its final entry.
  // ---------------------------------------------------------------------
  logic       in_v_r;
  in_item_t   in_r;
  logic [1:0] res_n_r;     // results still to deliver
  out_item_t  res_r [3];
  logic       take;
  logic       move;

  assign out_valid = (res_n_r != 2'd0);
  assign out_data  = res_r[0];
  assign take      = out_valid && !out_stall;
  assign move      = in_v_r && ((res_n_r == 2'd0) || ((res_n_r == 2'd1) && !out_stall));
  assign in_stall  = in_v_r && !move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------
  // Stream state
  // ---------------------------------------------------------------------
  logic [7:0]             pend_lead_r,  pend_lead_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic [2:0]             cont_left_r,  cont_left_nxt;
  logic [LENGTH_BITS-1:0] char_idx_r,   char_idx_nxt;
  logic [LENGTH_BITS-1:0] out_cnt_r,    out_cnt_nxt;
  logic                   slice_done_r, slice_done_nxt;

  // results of the request in the input register
  logic [1:0]  data_n;
  logic [7:0]  d0_byte, d1_byte;
  logic [15:0] d0_cnt,  d1_cnt;
  logic [1:0]  new_n;
  out_item_t   new_res [3];

  logic [7:0]             b;
  logic                   eos;
  logic [LENGTH_BITS-1:0] oc_inc1, oc_inc2, ci_inc;
  logic [2:0]             b_extra;
  logic                   in_range;
  logic                   at_last;
  out_item_t              summ;

  always_comb begin
    b        = in_r.in_byte;
    eos      = in_r.end_of_string;
    oc_inc1  = sat_inc(out_cnt_r);
    oc_inc2  = sat_inc(oc_inc1);
    ci_inc   = sat_inc(char_idx_r);
    b_extra  = extra_bytes(b);
    in_range = (SHOW_W'(char_idx_r) >= SHOW_W'(range_first_r)) &&
               (SHOW_W'(char_idx_r) <= SHOW_W'(range_last_r));
    at_last  = (SHOW_W'(char_idx_r) == SHOW_W'(range_last_r));

    pend_lead_nxt  = pend_lead_r;
    pend_valid_nxt = pend_valid_r;
    cont_left_nxt  = cont_left_r;
    char_idx_nxt   = char_idx_r;
    out_cnt_nxt    = out_cnt_r;
    slice_done_nxt = slice_done_r;
    data_n         = 2'd0;
    d0_byte        = b;
    d1_byte        = {2'b10, b[5:0]};
    d0_cnt         = shown(oc_inc1);
    d1_cnt         = shown(oc_inc2);

    case (mode_r)
      MODE_DECODE: begin
        if (pend_valid_r) begin
          // the byte after a lead is always its continuation
          d0_byte        = {pend_lead_r[1:0], b[5:0]};
          data_n         = 2'd1;
          out_cnt_nxt    = oc_inc1;
          pend_valid_nxt = 1'b0;
        end else if (!b[7]) begin
          data_n      = 2'd1;
          out_cnt_nxt = oc_inc1;
        end else begin
          pend_lead_nxt = b;
          if (eos) begin
            // string ends on a lead: zero continuation
            d0_byte     = {b[1:0], 6'b0};
            data_n      = 2'd1;
            out_cnt_nxt = oc_inc1;
          end else begin
            pend_valid_nxt = 1'b1;
          end
        end
      end
      MODE_ENCODE: begin
        if (!b[7]) begin
          data_n      = 2'd1;
          out_cnt_nxt = oc_inc1;
        end else begin
          d0_byte     = LEAD_2B | {6'b0, b[7:6]};
          d1_byte     = CONT_TAG | (b & CONT_MASK);
          data_n      = 2'd2;
          out_cnt_nxt = oc_inc2;
        end
      end
      MODE_COUNT: begin
        if (cont_left_r != 3'd0) begin
          cont_left_nxt = cont_left_r - 3'd1;
        end else begin
          char_idx_nxt  = ci_inc;
          cont_left_nxt = b_extra;
        end
      end
      MODE_SLICE: begin
        if (cont_left_r != 3'd0) begin
          cont_left_nxt = cont_left_r - 3'd1;
          d0_cnt        = shown(char_idx_r);
          if (pend_valid_r) begin
            data_n = 2'd1;
          end
          if (cont_left_r == 3'd1) begin
            pend_valid_nxt = 1'b0;
          end
        end else if (!slice_done_r) begin
          char_idx_nxt   = ci_inc;
          cont_left_nxt  = b_extra;
          pend_valid_nxt = in_range && (b_extra != 3'd0);
          d0_cnt         = shown(ci_inc);
          if (at_last) begin
            slice_done_nxt = 1'b1;
          end
          if (in_range) begin
            data_n = 2'd1;
          end
        end
      end
      default: ;
    endcase

    // end-of-string summary, then the stream starts afresh
    summ.out_byte    = '0;
    summ.is_summary  = 1'b1;
    summ.count       = (mode_r == MODE_DECODE || mode_r == MODE_ENCODE) ?
                       shown(out_cnt_nxt) : shown(char_idx_nxt);
    summ.status      = (mode_r == MODE_SLICE) && !slice_done_nxt;
    summ.last_of_run = 1'b1;

    new_res[0] = '{out_byte: d0_byte, is_summary: 1'b0, count: d0_cnt,
                   status: 1'b0, last_of_run: (data_n == 2'd1) && !eos};
    new_res[1] = '{out_byte: d1_byte, is_summary: 1'b0, count: d1_cnt,
                   status: 1'b0, last_of_run: !eos};
    new_res[2] = summ;
    new_n      = data_n;

    if (eos) begin
      new_n = data_n + 2'd1;
      case (data_n)
        2'd0:    new_res[0] = summ;
        2'd1:    new_res[1] = summ;
        default: new_res[2] = summ;
      endcase
      pend_lead_nxt  = '0;
      pend_valid_nxt = 1'b0;
      cont_left_nxt  = '0;
      char_idx_nxt   = '0;
      out_cnt_nxt    = '0;
      slice_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || mode_wr) begin
      pend_lead_r  <= '0;
      pend_valid_r <= 1'b0;
      cont_left_r  <= '0;
      char_idx_r   <= '0;
      out_cnt_r    <= '0;
      slice_done_r <= 1'b0;
    end else if (move) begin
      pend_lead_r  <= pend_lead_nxt;
      pend_valid_r <= pend_valid_nxt;
      cont_left_r  <= cont_left_nxt;
      char_idx_r   <= char_idx_nxt;
      out_cnt_r    <= out_cnt_nxt;
      slice_done_r <= slice_done_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: up to three entries of one request, shifted out
  // from entry 0 one per taken result.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_n_r <= 2'd0;
    end else if (move) begin
      res_n_r <= new_n;
    end else if (take) begin
      res_n_r <= res_n_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_r[0] <= new_res[0];
      res_r[1] <= new_res[1];
      res_r[2] <= new_res[2];
    end else if (take) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ULT_ASSERT(a_summary_ends_run, out_valid && out_data.is_summary |-> out_data.last_of_run && (out_data.out_byte == 8'd0), "summary result must close its run with a zero byte")
  `ULT_ASSERT(a_status_in_summary, out_valid && !out_data.is_summary |-> !out_data.status, "status raised on a data result")
  `ULT_ASSERT(a_run_drains, out_valid && !out_stall && out_data.last_of_run && !in_v_r |=> !out_valid, "results left over after the final result of a run")
  `ULT_ASSERT(a_pending_is_lead, pend_valid_r && (mode_r == MODE_DECODE) |-> pend_lead_r[7], "decode holds a pending lead below 0x80")
  `ULT_ASSERT_ALWAYS(a_done_only_slice, rst_n && slice_done_r |-> (mode_r == MODE_SLICE), "slice end flag set outside slice mode")

endmodule
